>>> rtl/xcfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sync-header frame parser.
package xcfp_pkg;

	localparam int PosWidth = 4;
	localparam int ApbAddrW = 5;
	localparam int QDepth = 2;
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW = $clog2(QDepth + 1);

	// Byte positions within a frame
	localparam logic [PosWidth-1:0] POS_SYNC1    = 4'd0;
	localparam logic [PosWidth-1:0] POS_SYNC2    = 4'd1;
	localparam logic [PosWidth-1:0] POS_TYPE     = 4'd2;
	localparam logic [PosWidth-1:0] POS_STEER_LO = 4'd3;
	localparam logic [PosWidth-1:0] POS_STEER_HI = 4'd4;
	localparam logic [PosWidth-1:0] POS_FLAGS    = 4'd5;
	localparam logic [PosWidth-1:0] POS_AUX_LO   = 4'd6;
	localparam logic [PosWidth-1:0] POS_AUX_HI   = 4'd7;
	localparam logic [PosWidth-1:0] POS_CHECK    = 4'd8;

	localparam logic [15:0] OtherSteerLimit = 16'd1000;

	typedef enum logic [2:0] {
		ST_ABSORBED     = 3'd0,
		ST_ACCEPTED     = 3'd1,
		ST_BAD_CHECKSUM = 3'd2,
		ST_BAD_PAYLOAD  = 3'd3,
		ST_RESYNC       = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_SYNC_FIRST   = 3'd0,
		REG_SYNC_SECOND  = 3'd1,
		REG_TYPE_LOWEST  = 3'd2,
		REG_TYPE_HIGHEST = 3'd3,
		REG_BALL_LIMIT   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [7:0]  type_lowest;
		logic [7:0]  type_highest;
		logic [14:0] ball_steer_limit;
	} cfg_t;

	// One classified transaction handed from front to back
	typedef struct packed {
		logic               clr;
		status_t            status;
		logic [7:0]         ftype;
		logic signed [15:0] steer;
		logic               found;
		logic signed [15:0] aux;
	} event_t;

endpackage

>>> rtl/xcfp_in_if.sv
`timescale 1ns / 1ps
// Input byte channel interface.
interface xcfp_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

>>> rtl/xcfp_out_if.sv
`timescale 1ns / 1ps
// Result channel interface.
interface xcfp_out_if import xcfp_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [7:0]         latest_type;
	logic signed [15:0] latest_steer;
	logic               latest_found;
	logic signed [15:0] latest_aux;
	logic [31:0]        update_count;
	logic               have_result;
	logic [31:0]        frames_good;
	logic [31:0]        checksum_errors;
	logic [31:0]        payload_errors;
	logic [31:0]        resync_count;

	modport source (output valid, output status, output latest_type, output latest_steer,
		output latest_found, output latest_aux, output update_count, output have_result,
		output frames_good, output checksum_errors, output payload_errors,
		output resync_count, input ready);
	modport sink (input valid, input status, input latest_type, input latest_steer,
		input latest_found, input latest_aux, input update_count, input have_result,
		input frames_good, input checksum_errors, input payload_errors,
		input resync_count, output ready);
endinterface

>>> rtl/xcfp_front.sv
`timescale 1ns / 1ps
// Front end: header hunt, frame capture, running XOR and frame classification.
module xcfp_front import xcfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	xcfp_in_if.sink in_ch,
	output logic   ev_push,
	output event_t ev,
	input  logic   ev_ready
);

	logic [PosWidth-1:0] pos_q, pos_n;
	logic [7:0] xor_q, xor_n;
	logic [7:0] type_q, steer_lo_q, steer_hi_q, flags_q, aux_lo_q, aux_hi_q;
	logic [7:0] b;
	logic       take;
	logic signed [15:0] steer;
	logic [15:0] steer_mag;
	logic [15:0] limit;
	logic        payload_bad;

	assign in_ch.ready = ev_ready;
	assign take = in_ch.valid && ev_ready;
	assign ev_push = take;
	assign b = in_ch.data_byte;

	assign steer = $signed({steer_hi_q, steer_lo_q});
	// most negative steer maps to 0x8000, above any 15-bit limit
	assign steer_mag = steer[15] ? (16'd0 - $unsigned(steer)) : $unsigned(steer);
	assign limit = (type_q == cfg.type_highest) ? {1'b0, cfg.ball_steer_limit}
		: OtherSteerLimit;
	assign payload_bad = (type_q < cfg.type_lowest) || (type_q > cfg.type_highest)
		|| (steer_mag > limit);

	always_comb begin
		pos_n = pos_q;
		xor_n = xor_q;
		ev.clr = 1'b0;
		ev.status = ST_ABSORBED;
		ev.ftype = type_q;
		ev.steer = steer;
		ev.found = flags_q[0];
		ev.aux = $signed({aux_hi_q, aux_lo_q});
		if (in_ch.action) begin
			ev.clr = 1'b1;
			pos_n = POS_SYNC1;
		end else begin
			case (pos_q)
				POS_SYNC1: begin
					if (b == cfg.sync_first) pos_n = POS_SYNC2;
					else ev.status = ST_RESYNC;
				end
				POS_SYNC2: begin
					if (b == cfg.sync_second) begin
						pos_n = POS_TYPE;
					end else begin
						ev.status = ST_RESYNC;
						pos_n = (b == cfg.sync_first) ? POS_SYNC2 : POS_SYNC1;
					end
				end
				POS_TYPE: begin
					xor_n = b;
					pos_n = pos_q + 4'd1;
				end
				POS_STEER_LO, POS_STEER_HI, POS_FLAGS, POS_AUX_LO, POS_AUX_HI: begin
					xor_n = xor_q ^ b;
					pos_n = pos_q + 4'd1;
				end
				POS_CHECK: begin
					pos_n = POS_SYNC1;
					if (xor_q != b) ev.status = ST_BAD_CHECKSUM;
					else if (payload_bad) ev.status = ST_BAD_PAYLOAD;
					else ev.status = ST_ACCEPTED;
				end
				default: pos_n = POS_SYNC1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_SYNC1;
		end else if (take) begin
			pos_q <= pos_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !in_ch.action) begin
			xor_q <= xor_n;
			if (pos_q == POS_TYPE) type_q <= b;
			if (pos_q == POS_STEER_LO) steer_lo_q <= b;
			if (pos_q == POS_STEER_HI) steer_hi_q <= b;
			if (pos_q == POS_FLAGS) flags_q <= b;
			if (pos_q == POS_AUX_LO) aux_lo_q <= b;
			if (pos_q == POS_AUX_HI) aux_hi_q <= b;
		end
	end

endmodule

>>> rtl/xcfp_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified transactions between front and back.
module xcfp_queue import xcfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_data,
	output logic   push_ready,
	input  logic   pop,
	output logic   pop_valid,
	output event_t pop_data
);

	event_t mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != QCntW'(QDepth));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
		return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> rtl/xcfp_back.sv
`timescale 1ns / 1ps
// Back end: latest result, statistics counters and the result register.
module xcfp_back import xcfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ev_valid,
	input  event_t ev,
	output logic   ev_pop,
	xcfp_out_if.source out_ch
);

	logic               out_valid_q;
	status_t            status_q;
	logic [7:0]         type_q;
	logic signed [15:0] steer_q;
	logic               found_q;
	logic signed [15:0] aux_q;
	logic [31:0]        updates_q, good_q, cksum_q, payload_q, discard_q;

	assign ev_pop = ev_valid && (!out_valid_q || out_ch.ready);

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = status_q;
	assign out_ch.latest_type = type_q;
	assign out_ch.latest_steer = steer_q;
	assign out_ch.latest_found = found_q;
	assign out_ch.latest_aux = aux_q;
	assign out_ch.update_count = updates_q;
	assign out_ch.have_result = (updates_q != 32'd0);
	assign out_ch.frames_good = good_q;
	assign out_ch.checksum_errors = cksum_q;
	assign out_ch.payload_errors = payload_q;
	assign out_ch.resync_count = discard_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q <= ST_ABSORBED;
			type_q <= '0;
			steer_q <= '0;
			found_q <= 1'b0;
			aux_q <= '0;
			updates_q <= '0;
			good_q <= '0;
			cksum_q <= '0;
			payload_q <= '0;
			discard_q <= '0;
		end else begin
			if (ev_pop) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (ev_pop) begin
				status_q <= ev.status;
				if (ev.clr) begin
					type_q <= '0;
					steer_q <= '0;
					found_q <= 1'b0;
					aux_q <= '0;
					updates_q <= '0;
					good_q <= '0;
					cksum_q <= '0;
					payload_q <= '0;
					discard_q <= '0;
				end else begin
					case (ev.status)
						ST_ACCEPTED: begin
							type_q <= ev.ftype;
							steer_q <= ev.steer;
							found_q <= ev.found;
							aux_q <= ev.aux;
							updates_q <= updates_q + 32'd1;
							good_q <= good_q + 32'd1;
						end
						ST_BAD_CHECKSUM: cksum_q <= cksum_q + 32'd1;
						ST_BAD_PAYLOAD: payload_q <= payload_q + 32'd1;
						ST_RESYNC: discard_q <= discard_q + 32'd1;
						default: ;
					endcase
				end
			end
		end
	end

endmodule

>>> rtl/xor_checked_frame_parser_core.sv
`timescale 1ns / 1ps
// Top level of the sync-header frame parser with XOR checksum.
//
// Usage:
//  - in_ch carries one transaction per received byte: action 0 feeds data_byte,
//    action 1 clears parser, latest result and statistics counters.
//  - out_ch returns exactly one transaction per input transaction, in order:
//    a status code, the latest accepted frame and five wrapping counters.
//  - Registers sync_first, sync_second, type_lowest, type_highest and
//    ball_steer_limit sit on the APB port at byte offsets 0, 4, 8, 12, 16;
//    write them only while the block is idle.
//  - An accepted byte passes through the queue and the result register to out_ch.
//  - Throughput: one byte per cycle while the queue has room; the front parser
//    classifies a byte combinationally and the back updates counters on pop.
//  - A two-entry queue sits between front and back. When out_ch stalls, the
//    result register holds, the queue fills, and in_ch.ready drops once the
//    queue is full; nothing is lost or repeated.
//  - Reset (arst_n low) returns registers to their defaults, clears counters,
//    the latest result and the parser, and empties the queue.
module xor_checked_frame_parser_core import xcfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	xcfp_in_if.sink             in_ch,
	xcfp_out_if.source          out_ch
);

	cfg_t   cfg_q;
	logic   cfg_wr;
	event_t fe_ev, q_ev;
	logic   fe_push, q_push_ready, q_valid, be_pop;

	// APB: zero wait states, register index from the word address
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first <= 8'hAA;
			cfg_q.sync_second <= 8'h55;
			cfg_q.type_lowest <= 8'd1;
			cfg_q.type_highest <= 8'd4;
			cfg_q.ball_steer_limit <= 15'd10000;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_SYNC_FIRST: cfg_q.sync_first <= pwdata[7:0];
				REG_SYNC_SECOND: cfg_q.sync_second <= pwdata[7:0];
				REG_TYPE_LOWEST: cfg_q.type_lowest <= pwdata[7:0];
				REG_TYPE_HIGHEST: cfg_q.type_highest <= pwdata[7:0];
				REG_BALL_LIMIT: cfg_q.ball_steer_limit <= pwdata[14:0];
				default: ;  // unmapped offsets ignore writes
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_SYNC_FIRST: prdata = {24'd0, cfg_q.sync_first};
			REG_SYNC_SECOND: prdata = {24'd0, cfg_q.sync_second};
			REG_TYPE_LOWEST: prdata = {24'd0, cfg_q.type_lowest};
			REG_TYPE_HIGHEST: prdata = {24'd0, cfg_q.type_highest};
			REG_BALL_LIMIT: prdata = {17'd0, cfg_q.ball_steer_limit};
			default: prdata = 32'd0;
		endcase
	end

	// Front: header hunt and frame classification, one byte per cycle while the queue has room
	xcfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_ch    (in_ch),
		.ev_push  (fe_push),
		.ev       (fe_ev),
		.ev_ready (q_push_ready)
	);

	// Decoupling queue, lets front and back stall independently
	xcfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fe_push),
		.push_data  (fe_ev),
		.push_ready (q_push_ready),
		.pop        (be_pop),
		.pop_valid  (q_valid),
		.pop_data   (q_ev)
	);

	// Back: result and counter update, registered output
	xcfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (q_valid),
		.ev       (q_ev),
		.ev_pop   (be_pop),
		.out_ch   (out_ch)
	);

	// Front only pushes when the queue has room
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		fe_push |-> q_push_ready)
		else $error("push into full queue");

	// Back only pops real entries
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		be_pop |-> q_valid)
		else $error("pop from empty queue");

	// An accepted frame bumps the update count by exactly one
	a_update_step: assert property (@(posedge clk) disable iff (!arst_n)
		(be_pop && !q_ev.clr && (q_ev.status == ST_ACCEPTED))
		|=> (out_ch.update_count == $past(out_ch.update_count) + 32'd1))
		else $error("update count did not advance on accepted frame");

endmodule
